/* hdl/integer_to_ascii_formatter_macros.svh */
// Assertion macros for the integer to ASCII formatter.
// Used by the controller; needs i_clk and i_rst_n in the including scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/itaf_pkg.sv */
// Shared types, constants and character tables of the integer to ASCII formatter.
// No dependencies.
package itaf_pkg;

    localparam int POINTER_BYTES = 8;
    localparam int PTR_NIB       = 2 * POINTER_BYTES;
    localparam int PTR_BITS      = 4 * PTR_NIB;
    localparam int DIG_N         = 20;
    localparam int DIG_W         = 4 * DIG_N;
    localparam int CNT_W         = $clog2(DIG_N + 1);
    localparam int BIN_W         = 64;
    localparam int STEP_W        = $clog2(BIN_W);
    localparam int BAD_LEN       = 10;
    localparam int BAD_W         = $clog2(BAD_LEN);

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEX  = 3'd2;
    localparam logic [2:0] CMD_PTR  = 3'd3;

    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_HASH  = 8'h23;

    typedef enum logic [1:0] {KIND_DEC, KIND_HEX, KIND_BAD} t_kind;
    typedef enum logic [1:0] {EM_PFX, EM_DIG, EM_BAD} t_emit_sel;
    typedef enum logic [2:0] {
        ST_IDLE, ST_CONV, ST_SKIP, ST_PFX, ST_DIG, ST_BAD
    } t_state;

    typedef struct packed {
        logic      load;
        logic      conv;
        logic      skip;
        logic      emit;
        t_emit_sel sel;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  conv_done;
        logic  skip_done;
        logic  has_pfx;
        logic  dig_last;
        logic  bad_last;
        logic  out_free;
    } t_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'b0, nib};
        end else begin
            c = 8'h57 + {4'b0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] bad_char(input logic [BAD_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            BAD_W'(0): c = 8'h3c;
            BAD_W'(1): c = 8'h62;
            BAD_W'(2): c = 8'h61;
            BAD_W'(3): c = 8'h64;
            BAD_W'(4): c = 8'h76;
            BAD_W'(5): c = 8'h61;
            BAD_W'(6): c = 8'h6c;
            BAD_W'(7): c = 8'h75;
            BAD_W'(8): c = 8'h65;
            BAD_W'(9): c = 8'h3e;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/itaf_dpath.sv */
// Datapath: operand load, bit-serial binary to BCD, leading-digit skip,
// character selection and output register. Depends on itaf_pkg.
module itaf_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [71:0]           s_axis_tdata,  // value[63:0], min_width[71:64]
    input  logic [4:0]            s_axis_tuser,  // command[2:0], wide[3], zero_fill[4]
    input  itaf_pkg::t_cmd        i_cmd,
    output itaf_pkg::t_sts        o_sts,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // char_out[7:0]
    output logic                  m_axis_tlast
);

    logic [63:0] in_value;
    logic [7:0]  in_min_width;
    logic [2:0]  in_command;
    logic        in_wide;
    logic        in_zero_fill;
    logic [31:0] mag32;
    logic        neg;

    logic [itaf_pkg::BIN_W-1:0]  r_bin;
    logic [itaf_pkg::DIG_W-1:0]  r_dig;
    logic [itaf_pkg::STEP_W-1:0] r_step;
    logic [itaf_pkg::CNT_W-1:0]  r_cnt;
    logic [7:0]                  r_keep;
    logic                        r_has_pfx;
    logic [7:0]                  r_pfx;
    logic [itaf_pkg::BAD_W-1:0]  r_bad_idx;
    logic                        r_out_valid;
    logic [7:0]                  r_out_data;
    logic                        r_out_last;

    logic [itaf_pkg::DIG_W-1:0]  adj;
    logic                        skip_go;
    logic [7:0]                  n_char;
    logic                        n_last;
    itaf_pkg::t_kind             kind;

    assign in_value     = s_axis_tdata[63:0];
    assign in_min_width = s_axis_tdata[71:64];
    assign in_command   = s_axis_tuser[2:0];
    assign in_wide      = s_axis_tuser[3];
    assign in_zero_fill = s_axis_tuser[4];
    assign mag32        = ~in_value[31:0] + 32'd1;
    assign neg          = (in_command == itaf_pkg::CMD_SDEC) && !in_wide && in_value[31];

    always_comb begin
        priority if (in_command == itaf_pkg::CMD_SDEC || in_command == itaf_pkg::CMD_UDEC) begin
            kind = itaf_pkg::KIND_DEC;
        end else if (in_command == itaf_pkg::CMD_HEX || in_command == itaf_pkg::CMD_PTR) begin
            kind = itaf_pkg::KIND_HEX;
        end else begin
            kind = itaf_pkg::KIND_BAD;
        end
    end

    // add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < itaf_pkg::DIG_N; i++) begin
            adj[i*4 +: 4] = (r_dig[i*4 +: 4] >= 4'd5) ? r_dig[i*4 +: 4] + 4'd3
                                                      : r_dig[i*4 +: 4];
        end
    end

    assign skip_go = (r_dig[itaf_pkg::DIG_W-1 -: 4] == 4'd0)
                  && (r_cnt > itaf_pkg::CNT_W'(1))
                  && ({{(8-itaf_pkg::CNT_W){1'b0}}, r_cnt} > r_keep);

    always_comb begin
        unique case (i_cmd.sel)
            itaf_pkg::EM_PFX: begin
                n_char = r_pfx;
                n_last = 1'b0;
            end
            itaf_pkg::EM_DIG: begin
                n_char = itaf_pkg::hex_char(r_dig[itaf_pkg::DIG_W-1 -: 4]);
                n_last = (r_cnt == itaf_pkg::CNT_W'(1));
            end
            itaf_pkg::EM_BAD: begin
                n_char = itaf_pkg::bad_char(r_bad_idx);
                n_last = (r_bad_idx == itaf_pkg::BAD_W'(itaf_pkg::BAD_LEN - 1));
            end
            default: begin
                n_char = 8'h00;
                n_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step    <= '0;
            r_bad_idx <= '0;
            unique case (kind)
                itaf_pkg::KIND_DEC: begin
                    r_bin     <= neg ? {32'd0, mag32}
                               : (in_wide ? in_value : {32'd0, in_value[31:0]});
                    r_dig     <= '0;
                    r_cnt     <= itaf_pkg::CNT_W'(itaf_pkg::DIG_N);
                    r_keep    <= 8'd1;
                    r_has_pfx <= neg;
                    r_pfx     <= itaf_pkg::CHR_MINUS;
                end
                itaf_pkg::KIND_HEX: begin
                    if (in_command == itaf_pkg::CMD_PTR) begin
                        r_dig     <= {in_value[itaf_pkg::PTR_BITS-1:0],
                                      {(itaf_pkg::DIG_W-itaf_pkg::PTR_BITS){1'b0}}};
                        r_cnt     <= itaf_pkg::CNT_W'(itaf_pkg::PTR_NIB);
                        r_keep    <= 8'(itaf_pkg::POINTER_BYTES);
                        r_has_pfx <= 1'b1;
                    end else begin
                        r_dig     <= in_wide ? {in_value, 16'd0} : {in_value[31:0], 48'd0};
                        r_cnt     <= in_wide ? itaf_pkg::CNT_W'(16) : itaf_pkg::CNT_W'(8);
                        r_keep    <= in_zero_fill ? in_min_width : 8'd0;
                        r_has_pfx <= 1'b0;
                    end
                    r_pfx <= itaf_pkg::CHR_HASH;
                end
                default: begin
                    r_has_pfx <= 1'b0;
                end
            endcase
        end else if (i_cmd.conv) begin
            r_dig  <= {adj[itaf_pkg::DIG_W-2:0], r_bin[itaf_pkg::BIN_W-1]};
            r_bin  <= {r_bin[itaf_pkg::BIN_W-2:0], 1'b0};
            r_step <= r_step + itaf_pkg::STEP_W'(1);
        end else if (i_cmd.skip || (i_cmd.emit && i_cmd.sel == itaf_pkg::EM_DIG)) begin
            r_dig <= {r_dig[itaf_pkg::DIG_W-5:0], 4'd0};
            r_cnt <= r_cnt - itaf_pkg::CNT_W'(1);
        end else if (i_cmd.emit && i_cmd.sel == itaf_pkg::EM_BAD) begin
            r_bad_idx <= r_bad_idx + itaf_pkg::BAD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= n_char;
            r_out_last <= n_last;
        end
    end

    assign o_sts.kind      = kind;
    assign o_sts.conv_done = (r_step == {itaf_pkg::STEP_W{1'b1}});
    assign o_sts.skip_done = !skip_go;
    assign o_sts.has_pfx   = r_has_pfx;
    assign o_sts.dig_last  = (r_cnt == itaf_pkg::CNT_W'(1));
    assign o_sts.bad_last  = (r_bad_idx == itaf_pkg::BAD_W'(itaf_pkg::BAD_LEN - 1));
    assign o_sts.out_free  = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

/* hdl/itaf_ctrl.sv */
// Controller state machine: sequences load, conversion, digit skip and emission.
// Depends on itaf_pkg and integer_to_ascii_formatter_macros.svh.
`include "integer_to_ascii_formatter_macros.svh"

module itaf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  itaf_pkg::t_sts i_sts,
    output itaf_pkg::t_cmd o_cmd
);

    itaf_pkg::t_state r_state;
    itaf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itaf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itaf_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (i_sts.kind)
                        itaf_pkg::KIND_DEC: n_state = itaf_pkg::ST_CONV;
                        itaf_pkg::KIND_HEX: n_state = itaf_pkg::ST_SKIP;
                        default:            n_state = itaf_pkg::ST_BAD;
                    endcase
                end
            end
            itaf_pkg::ST_CONV: begin
                if (i_sts.conv_done) n_state = itaf_pkg::ST_SKIP;
            end
            itaf_pkg::ST_SKIP: begin
                if (i_sts.skip_done) begin
                    n_state = i_sts.has_pfx ? itaf_pkg::ST_PFX : itaf_pkg::ST_DIG;
                end
            end
            itaf_pkg::ST_PFX: begin
                if (i_sts.out_free) n_state = itaf_pkg::ST_DIG;
            end
            itaf_pkg::ST_DIG: begin
                if (i_sts.out_free && i_sts.dig_last) n_state = itaf_pkg::ST_IDLE;
            end
            itaf_pkg::ST_BAD: begin
                if (i_sts.out_free && i_sts.bad_last) n_state = itaf_pkg::ST_IDLE;
            end
            default: n_state = itaf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == itaf_pkg::ST_IDLE);
        o_cmd.load    = (r_state == itaf_pkg::ST_IDLE) && s_axis_tvalid;
        o_cmd.conv    = (r_state == itaf_pkg::ST_CONV);
        o_cmd.skip    = (r_state == itaf_pkg::ST_SKIP) && !i_sts.skip_done;
        o_cmd.emit    = 1'b0;
        o_cmd.sel     = itaf_pkg::EM_DIG;
        unique case (r_state)
            itaf_pkg::ST_PFX: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = itaf_pkg::EM_PFX;
            end
            itaf_pkg::ST_DIG: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = itaf_pkg::EM_DIG;
            end
            itaf_pkg::ST_BAD: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = itaf_pkg::EM_BAD;
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    `ITAF_ASSERT_NEXT(a_load_leaves_idle, o_cmd.load, r_state != itaf_pkg::ST_IDLE,
                      "load did not leave idle")
    `ITAF_ASSERT_NEXT(a_conv_holds, (r_state == itaf_pkg::ST_CONV) && !i_sts.conv_done,
                      r_state == itaf_pkg::ST_CONV, "conversion cut short")
    `ITAF_ASSERT_NEXT(a_last_digit_ends,
                      o_cmd.emit && (o_cmd.sel == itaf_pkg::EM_DIG) && i_sts.dig_last,
                      r_state == itaf_pkg::ST_IDLE, "final digit did not end item")
    `ITAF_ASSERT_NOW(a_no_skip_emit, r_state == itaf_pkg::ST_SKIP,
                     !o_cmd.emit && !o_cmd.load, "skip overlaps emit or load")

endmodule

/* hdl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
// Depends on itaf_pkg, itaf_ctrl and itaf_dpath.
//
// Usage: one transaction on the s_axis side carries an integer and its format;
// the m_axis side returns its text one ASCII character per transaction, with
// tlast on the final character. Each item yields 1 to 20 characters.
// Per item: the accepting handshake loads the operand; decimal formats then run
// bit-serial binary-to-BCD over the whole 64-bit binary register (one operand
// bit per cycle through the BCD register); decimal and hex drop leading zero
// digits at one digit per cycle (up to 19); a minus sign or '#' is emitted
// next; then one character leaves per cycle while the receiver is ready.
// s_axis_tready is high only between items; the output register lets the next
// item load while the final character waits.
// A stalled receiver holds the current character and freezes emission.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register; no text in flight survives it.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[63:0], min_width[71:64]
    input  logic [4:0]  s_axis_tuser,   // command[2:0], wide[3], zero_fill[4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // char_out[7:0]
    output logic        m_axis_tlast    // last
);

    itaf_pkg::t_cmd cmd;
    itaf_pkg::t_sts sts;

    itaf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    itaf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
